// File: design/lbtc_pkg.sv
// Shared constants, types and codes for the block tag cache.
`default_nettype none
package lbtc_pkg;

    // Entry store size and the index widths that follow from it
    localparam int NUM_ENTRIES = 8;
    localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    // Transaction field widths
    localparam int REQ_W   = 2;
    localparam int BLK_W   = 31;
    localparam int OFF_W   = 16;
    localparam int WAY_W   = 3;
    localparam int MASK_W  = 8;
    localparam int MASK_IDX_W = $clog2(MASK_W);
    localparam int STAMP_W = 64;

    // Block size register and divider
    localparam int BS_W       = 17;
    localparam int DIV_STEPS  = BLK_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam logic [BS_W-1:0] DEFAULT_BLOCK_SIZE = 17'd1024;
    localparam logic [BS_W-1:0] MAX_BLOCK_SIZE     = 17'd65536;

    // Register port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_BLOCK_SIZE = 1'b0;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PROBE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ACCESS = 2'd1;
    localparam logic [REQ_W-1:0] REQ_INVAL  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_FIN,
        ST_DONE
    } t_state;

    // One entry as read from the store
    typedef struct packed {
        logic               valid;
        logic [BLK_W-1:0]   block;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // Store write command: fill sets valid, tag and stamp; touch refreshes the
    // stamp; drop clears valid
    typedef struct packed {
        logic               fill;
        logic               touch;
        logic               drop;
        logic [IDX_W-1:0]   idx;
        logic [BLK_W-1:0]   block;
        logic [STAMP_W-1:0] stamp;
    } t_store_wr;

endpackage
`default_nettype wire

// File: design/lru_block_tag_cache.sv
// Top level: sequencer, shared entry comparator, register port and result register.
//
//  Channel   Direction  Handshake                 Payload
//  request   in         i_in_valid / o_in_ready   i_req_type, i_cluster_index
//  result    out        o_out_valid / i_out_ready o_hit .. o_invalidated_mask
//  config    in         psel, penable, pwrite     paddr, pwdata, prdata
//
//  A transaction is accepted in the idle state, then runs through the serial divider
//  (31 quotient steps and a done strobe), the entry scan (up to NUM_ENTRIES entries,
//  one entry per cycle through the shared comparator, none for the unused request
//  code), an update state and a state that loads the result. A new request is
//  taken only when the sequencer is idle. A stalled result holds in the output
//  register; the next finished result waits until it is taken. Reset clears all
//  valid bits at once.
`default_nettype none
module lru_block_tag_cache (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // register port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lbtc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [lbtc_pkg::DATA_W-1:0] pwdata,
    output logic [lbtc_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,
    // request channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [lbtc_pkg::REQ_W-1:0]  i_req_type,
    input  wire logic [lbtc_pkg::BLK_W-1:0]  i_cluster_index,
    // result channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_hit,
    output logic [lbtc_pkg::WAY_W-1:0]       o_way,
    output logic                             o_evicted,
    output logic [lbtc_pkg::BLK_W-1:0]       o_evicted_block,
    output logic [lbtc_pkg::BLK_W-1:0]       o_block_number,
    output logic [lbtc_pkg::OFF_W-1:0]       o_offset_in_block,
    output logic [lbtc_pkg::MASK_W-1:0]      o_invalidated_mask
);
    import lbtc_pkg::*;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_ENTRIES - 1);

    t_state r_state, n_state;

    // configuration
    logic [BS_W-1:0]    r_bs;
    logic [BS_W-1:0]    eff_bs;
    logic               cfg_wr;

    // transaction context
    logic [REQ_W-1:0]   r_req;
    logic [BLK_W-1:0]   r_blk;
    logic [OFF_W-1:0]   r_off;
    logic [IDX_W-1:0]   r_idx;
    logic               r_found;
    logic [IDX_W-1:0]   r_found_idx;
    logic               r_have_inv;
    logic [IDX_W-1:0]   r_inv_idx;
    logic [STAMP_W-1:0] r_best_stamp;
    logic [IDX_W-1:0]   r_best_idx;
    logic [BLK_W-1:0]   r_best_blk;
    logic [MASK_W-1:0]  r_mask;
    logic [STAMP_W-1:0] r_usage;

    // finished result
    logic               r_res_hit;
    logic [WAY_W-1:0]   r_res_way;
    logic               r_res_ev;
    logic [BLK_W-1:0]   r_res_evblk;
    logic [MASK_W-1:0]  r_res_mask;

    // output register
    logic               r_out_valid;
    logic               r_o_hit;
    logic [WAY_W-1:0]   r_o_way;
    logic               r_o_ev;
    logic [BLK_W-1:0]   r_o_evblk;
    logic [BLK_W-1:0]   r_o_blk;
    logic [OFF_W-1:0]   r_o_off;
    logic [MASK_W-1:0]  r_o_mask;

    // divider and store
    logic               div_start;
    logic               div_done;
    logic [BLK_W-1:0]   div_quot;
    logic [OFF_W-1:0]   div_rem;
    t_entry             entry;
    t_store_wr          st_wr;

    // shared comparator
    logic               cmp_eq;
    logic               cmp_ge;
    logic               cmp_lt;
    logic               is_lookup;
    logic               accept_in;
    logic               load_out;
    logic [IDX_W-1:0]   victim;
    logic [STAMP_W-1:0] next_stamp;

    // Register port: single block size register, writes need no wait
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs <= DEFAULT_BLOCK_SIZE;
        end else if (cfg_wr && paddr[2] == REG_BLOCK_SIZE) begin
            r_bs <= pwdata[BS_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_BLOCK_SIZE) ? DATA_W'(r_bs) : '0;

    // Clamp the divisor: zero means the default, above the limit saturates
    always_comb begin
        if (r_bs == '0) begin
            eff_bs = DEFAULT_BLOCK_SIZE;
        end else if (r_bs > MAX_BLOCK_SIZE) begin
            eff_bs = MAX_BLOCK_SIZE;
        end else begin
            eff_bs = r_bs;
        end
    end

    lbtc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_cluster_index),
        .i_divisor  (eff_bs),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    lbtc_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (r_idx),
        .o_entry  (entry),
        .i_wr     (st_wr)
    );

    // Compare the scanned entry against the key and the best stamp so far
    always_comb begin
        cmp_eq = entry.valid && (entry.block == r_blk);
        cmp_ge = entry.valid && (entry.block >= r_blk);
        cmp_lt = entry.stamp < r_best_stamp;
    end

    assign is_lookup  = (r_req == REQ_PROBE) || (r_req == REQ_ACCESS);
    assign accept_in  = i_in_valid && o_in_ready;
    assign load_out   = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    assign victim     = r_have_inv ? r_inv_idx : r_best_idx;
    assign next_stamp = r_usage + 1'b1;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, divider start and store writes
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        div_start  = 1'b0;
        st_wr      = '0;
        st_wr.idx  = r_idx;
        st_wr.block = r_blk;
        st_wr.stamp = next_stamp;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (is_lookup || r_req == REQ_INVAL) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_SCAN: begin
                if (is_lookup) begin
                    if (cmp_eq || r_idx == IDX_LAST) begin
                        n_state = ST_FIN;
                    end
                end else begin
                    st_wr.drop = cmp_ge;
                    if (r_idx == IDX_LAST) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (r_req == REQ_ACCESS) begin
                    if (r_found) begin
                        st_wr.touch = 1'b1;
                        st_wr.idx   = r_found_idx;
                    end else begin
                        st_wr.fill = 1'b1;
                        st_wr.idx  = victim;
                    end
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Usage counter: advance on every stamped access
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_usage <= STAMP_W'(1);
        end else if (r_state == ST_FIN && r_req == REQ_ACCESS) begin
            r_usage <= next_stamp;
        end
    end

    // Transaction context and scan trackers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (accept_in) begin
                    r_req <= i_req_type;
                end
                r_found    <= 1'b0;
                r_have_inv <= 1'b0;
                r_mask     <= '0;
                r_idx      <= '0;
            end
            ST_DIV: begin
                if (div_done) begin
                    r_blk <= div_quot;
                    r_off <= div_rem;
                end
            end
            ST_SCAN: begin
                if (is_lookup) begin
                    if (cmp_eq) begin
                        r_found     <= 1'b1;
                        r_found_idx <= r_idx;
                    end else if (!r_have_inv) begin
                        // track the first free entry, else the oldest stamp
                        if (!entry.valid) begin
                            r_have_inv <= 1'b1;
                            r_inv_idx  <= r_idx;
                        end else if (r_idx == '0 || cmp_lt) begin
                            r_best_stamp <= entry.stamp;
                            r_best_idx   <= r_idx;
                            r_best_blk   <= entry.block;
                        end
                    end
                end else if (cmp_ge && int'(r_idx) < MASK_W) begin
                    r_mask[MASK_IDX_W'(r_idx)] <= 1'b1;
                end
                if (r_idx != IDX_LAST) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            ST_FIN: begin
                r_res_hit   <= 1'b0;
                r_res_way   <= '0;
                r_res_ev    <= 1'b0;
                r_res_evblk <= '0;
                r_res_mask  <= '0;
                case (r_req)
                    REQ_PROBE: begin
                        r_res_hit <= r_found;
                        if (r_found) begin
                            r_res_way <= WAY_W'(r_found_idx);
                        end
                    end
                    REQ_ACCESS: begin
                        if (r_found) begin
                            r_res_hit <= 1'b1;
                            r_res_way <= WAY_W'(r_found_idx);
                        end else begin
                            r_res_way <= WAY_W'(victim);
                            if (!r_have_inv) begin
                                r_res_ev    <= 1'b1;
                                r_res_evblk <= r_best_blk;
                            end
                        end
                    end
                    REQ_INVAL: begin
                        r_res_mask <= r_mask;
                    end
                    default: begin
                        r_res_mask <= '0;
                    end
                endcase
            end
            ST_DONE: begin
                r_idx <= '0;
            end
            default: begin
                r_idx <= '0;
            end
        endcase
    end

    // Output register: hold until the transaction is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_hit   <= r_res_hit;
            r_o_way   <= r_res_way;
            r_o_ev    <= r_res_ev;
            r_o_evblk <= r_res_evblk;
            r_o_blk   <= r_blk;
            r_o_off   <= r_off;
            r_o_mask  <= r_res_mask;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_hit              = r_o_hit;
    assign o_way              = r_o_way;
    assign o_evicted          = r_o_ev;
    assign o_evicted_block    = r_o_evblk;
    assign o_block_number     = r_o_blk;
    assign o_offset_in_block  = r_o_off;
    assign o_invalidated_mask = r_o_mask;

endmodule
`default_nettype wire

// File: design/lbtc_div.sv
// Serial restoring divider: one quotient bit per cycle.
`default_nettype none
module lbtc_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [lbtc_pkg::BLK_W-1:0] i_dividend,
    input  wire logic [lbtc_pkg::BS_W-1:0]  i_divisor,
    output logic                           o_done,
    output logic [lbtc_pkg::BLK_W-1:0]     o_quot,
    output logic [lbtc_pkg::OFF_W-1:0]     o_rem
);
    import lbtc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [BLK_W-1:0]     r_q;
    logic [OFF_W-1:0]     r_rem;
    logic [BS_W-1:0]      r_div;

    logic [BS_W-1:0]      shifted;
    logic [BS_W-1:0]      diff;
    logic                 q_bit;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        shifted = {r_rem, r_q[BLK_W-1]};
        diff    = shifted - r_div;
        q_bit   = (shifted >= r_div);
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift dividend out, quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[BLK_W-2:0], q_bit};
            r_rem <= q_bit ? diff[OFF_W-1:0] : shifted[OFF_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// File: design/lbtc_store.sv
// Entry store: valid bits, block tags and recency stamps.
`default_nettype none
module lbtc_store (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [lbtc_pkg::IDX_W-1:0] i_rd_idx,
    output lbtc_pkg::t_entry                o_entry,
    input  wire lbtc_pkg::t_store_wr        i_wr
);
    import lbtc_pkg::*;

    logic                 r_valid [NUM_ENTRIES];
    logic [BLK_W-1:0]     r_block [NUM_ENTRIES];
    logic [STAMP_W-1:0]   r_stamp [NUM_ENTRIES];

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (i_wr.fill) begin
            r_valid[i_wr.idx] <= 1'b1;
        end else if (i_wr.drop) begin
            r_valid[i_wr.idx] <= 1'b0;
        end
    end

    // Tags and stamps
    always_ff @(posedge i_clk) begin
        if (i_wr.fill) begin
            r_block[i_wr.idx] <= i_wr.block;
        end
        if (i_wr.fill || i_wr.touch) begin
            r_stamp[i_wr.idx] <= i_wr.stamp;
        end
    end

    // Read one entry per cycle
    always_comb begin
        o_entry.valid = r_valid[i_rd_idx];
        o_entry.block = r_block[i_rd_idx];
        o_entry.stamp = r_stamp[i_rd_idx];
    end

endmodule
`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the block tag cache: directed and random lookups against a predictor.
module tb_top;
    import lbtc_pkg::*;

    // Unused request code and register address
    localparam logic [REQ_W-1:0]  REQ_UNUSED      = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_BLOCK_SIZE = ADDR_W'(4 * REG_BLOCK_SIZE);
    localparam logic [BLK_W-1:0]  INDEX_MAX       = 31'h7FFF_FFFF;

    // One request as queued for the driver
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [BLK_W-1:0] idx;
        logic             drain;
    } t_request;

    // One lookup result
    typedef struct packed {
        logic               hit;
        logic [WAY_W-1:0]   way;
        logic               evicted;
        logic [BLK_W-1:0]   evicted_block;
        logic [BLK_W-1:0]   block_number;
        logic [OFF_W-1:0]   offset_in_block;
        logic [MASK_W-1:0]  invalidated_mask;
    } t_lookup;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                psel            = 1'b0;
    logic                penable         = 1'b0;
    logic                pwrite          = 1'b0;
    logic [ADDR_W-1:0]   paddr           = '0;
    logic [DATA_W-1:0]   pwdata          = '0;
    wire  [DATA_W-1:0]   prdata;
    wire                 pready;
    logic                i_in_valid      = 1'b0;
    wire                 o_in_ready;
    logic [REQ_W-1:0]    i_req_type      = '0;
    logic [BLK_W-1:0]    i_cluster_index = '0;
    wire                 o_out_valid;
    logic                i_out_ready     = 1'b0;
    wire                 o_hit;
    wire  [WAY_W-1:0]    o_way;
    wire                 o_evicted;
    wire  [BLK_W-1:0]    o_evicted_block;
    wire  [BLK_W-1:0]    o_block_number;
    wire  [OFF_W-1:0]    o_offset_in_block;
    wire  [MASK_W-1:0]   o_invalidated_mask;

    // Predictor copy of the tag store and register
    logic                tag_valid [NUM_ENTRIES];
    logic [BLK_W-1:0]    tag_block [NUM_ENTRIES];
    logic [STAMP_W-1:0]  tag_stamp [NUM_ENTRIES];
    logic [STAMP_W-1:0]  use_count;
    logic [BS_W-1:0]     cfg_block_size = DEFAULT_BLOCK_SIZE;

    // Stimulus and result bookkeeping
    t_request            request_fifo[$];
    t_lookup             lookup_results_due[$];
    int                  issued_cnt     = 0;
    int                  accepted_cnt   = 0;
    int                  checked_cnt    = 0;
    int                  mismatch_cnt   = 0;
    int                  hit_cnt        = 0;
    int                  evict_cnt      = 0;
    int                  drop_cnt       = 0;
    int                  setting_cnt    = 1;
    logic                req_taken      = 1'b0;
    int                  burst_left     = 1;
    int                  gap_left       = 0;
    int                  ready_left     = 0;

    lru_block_tag_cache u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_req_type         (i_req_type),
        .i_cluster_index    (i_cluster_index),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_hit              (o_hit),
        .o_way              (o_way),
        .o_evicted          (o_evicted),
        .o_evicted_block    (o_evicted_block),
        .o_block_number     (o_block_number),
        .o_offset_in_block  (o_offset_in_block),
        .o_invalidated_mask (o_invalidated_mask)
    );

    always #4 i_clk = ~i_clk;

    // Clamp the register to the block size actually used
    function automatic logic [BS_W-1:0] eff_block_size();
        if (cfg_block_size == '0) begin
            return DEFAULT_BLOCK_SIZE;
        end
        if (cfg_block_size > MAX_BLOCK_SIZE) begin
            return MAX_BLOCK_SIZE;
        end
        return cfg_block_size;
    endfunction

    // Work out the result of one request and update the predicted tag store
    function automatic t_lookup predict_lookup(logic [REQ_W-1:0] req, logic [BLK_W-1:0] idx);
        t_lookup            r;
        logic [BS_W-1:0]    bs;
        logic [BLK_W-1:0]   blk;
        logic [STAMP_W-1:0] oldest;
        int                 found;
        int                 victim;
        logic               stop;
        r      = '0;
        bs     = eff_block_size();
        blk    = idx / bs;
        r.block_number    = blk;
        r.offset_in_block = OFF_W'(idx % bs);
        if (req == REQ_PROBE || req == REQ_ACCESS) begin
            found = -1;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (found < 0 && tag_valid[i] && tag_block[i] == blk) begin
                    found = i;
                end
            end
            if (found >= 0) begin
                r.hit = 1'b1;
                r.way = WAY_W'(found);
                hit_cnt++;
                if (req == REQ_ACCESS) begin
                    use_count        = use_count + 1'b1;
                    tag_stamp[found] = use_count;
                end
            end else if (req == REQ_ACCESS) begin
                // First free entry wins, else the oldest stamp, lowest index on a tie
                victim = 0;
                oldest = tag_stamp[0];
                stop   = 1'b0;
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    if (!stop) begin
                        if (!tag_valid[i]) begin
                            victim = i;
                            stop   = 1'b1;
                        end else if (tag_stamp[i] < oldest) begin
                            oldest = tag_stamp[i];
                            victim = i;
                        end
                    end
                end
                if (tag_valid[victim]) begin
                    r.evicted       = 1'b1;
                    r.evicted_block = tag_block[victim];
                    evict_cnt++;
                end
                tag_valid[victim] = 1'b1;
                tag_block[victim] = blk;
                use_count         = use_count + 1'b1;
                tag_stamp[victim] = use_count;
                r.way             = WAY_W'(victim);
            end
        end else if (req == REQ_INVAL) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (tag_valid[i] && tag_block[i] >= blk) begin
                    tag_valid[i] = 1'b0;
                    if (i < MASK_W) begin
                        r.invalidated_mask[i] = 1'b1;
                    end
                    drop_cnt++;
                end
            end
        end
        return r;
    endfunction

    // Pick a cluster index that falls in the given block
    function automatic logic [BLK_W-1:0] cluster_of(logic [BLK_W-1:0] blk);
        longint unsigned bs;
        longint unsigned base;
        longint unsigned room;
        bs   = 64'(eff_block_size());
        base = longint'(blk) * bs;
        if (base > INDEX_MAX) begin
            base = (INDEX_MAX / bs) * bs;
        end
        room = INDEX_MAX - base;
        if (room > bs - 1) begin
            room = bs - 1;
        end
        return BLK_W'(base + $urandom_range(32'(room), 0));
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_cnt++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        end
    endtask

    task automatic push_request(logic [REQ_W-1:0] req, logic [BLK_W-1:0] idx,
                                logic drain = 1'b0);
        request_fifo.push_back('{req: req, idx: idx, drain: drain});
        issued_cnt++;
    endtask

    // Hold until every queued request has been taken and answered
    task automatic wait_idle();
        while (accepted_cnt != issued_cnt || lookup_results_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (50) @(negedge i_clk);
    endtask

    // Write the block size register with a setup phase and then an access phase
    task automatic write_block_size(logic [DATA_W-1:0] value);
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BLOCK_SIZE;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_block_size = value[BS_W-1:0];
        setting_cnt++;
    endtask

    // Queue a random phase around a working set a little larger than the store
    task automatic queue_random_phase(int n_items);
        logic [BLK_W-1:0] hot [16];
        logic [BLK_W-1:0] top;
        logic [BLK_W-1:0] base;
        int               spread;
        int               sel;
        logic             drain;
        top    = INDEX_MAX / eff_block_size();
        spread = $urandom_range(14, 9);
        case ($urandom_range(2, 0))
            0:       base = '0;
            1:       base = (top > spread) ? top - BLK_W'(spread) : '0;
            default: base = BLK_W'($urandom_range(32'(top), 0));
        endcase
        for (int k = 0; k < 16; k++) begin
            hot[k] = (top - base > k) ? base + BLK_W'(k) : top;
        end
        for (int n = 0; n < n_items; n++) begin
            sel   = $urandom_range(99, 0);
            drain = ($urandom_range(149, 0) == 0);
            if (sel < 18) begin
                push_request(REQ_PROBE, cluster_of(hot[$urandom_range(spread - 1, 0)]), drain);
            end else if (sel < 70) begin
                push_request(REQ_ACCESS, cluster_of(hot[$urandom_range(spread - 1, 0)]), drain);
            end else if (sel < 78) begin
                push_request(REQ_INVAL, cluster_of(hot[$urandom_range(spread - 1, 0)]), drain);
            end else if (sel < 80) begin
                push_request(REQ_INVAL, cluster_of(sel[0] ? top : '0), drain);
            end else if (sel < 84) begin
                push_request(REQ_UNUSED, BLK_W'($urandom), drain);
            end else begin
                push_request(REQ_W'($urandom), BLK_W'($urandom), drain);
            end
        end
    endtask

    // Sample accepted requests and predict their results
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            lookup_results_due.push_back(predict_lookup(i_req_type, i_cluster_index));
            accepted_cnt++;
            req_taken = 1'b1;
        end
    end

    // Drive requests in bursts with random gaps
    always @(negedge i_clk) begin : drive_requests
        t_request nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !req_taken) begin
            // hold until taken
        end else begin
            req_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (request_fifo.size() == 0 ||
                         (request_fifo[0].drain && lookup_results_due.size() != 0)) begin
                i_in_valid <= 1'b0;
            end else begin
                nxt = request_fifo.pop_front();
                i_in_valid      <= 1'b1;
                i_req_type      <= nxt.req;
                i_cluster_index <= nxt.idx;
                if (burst_left > 1) begin
                    burst_left--;
                end else if ($urandom_range(4, 0) == 0) begin
                    burst_left = $urandom_range(80, 30);
                    gap_left   = 0;
                end else begin
                    burst_left = $urandom_range(12, 1);
                    gap_left   = $urandom_range(60, 0);
                end
            end
        end
    end

    // Stall the result side on runs of random length
    always @(negedge i_clk) begin : drive_ready
        int mode;
        if (ready_left > 0) begin
            ready_left--;
        end else begin
            mode = $urandom_range(9, 0);
            if (mode < 2) begin
                i_out_ready <= 1'b0;
                ready_left  = $urandom_range(60, 1);
            end else if (mode < 4) begin
                i_out_ready <= 1'b0;
                ready_left  = $urandom_range(4, 1);
            end else if (mode == 4) begin
                i_out_ready <= 1'b1;
                ready_left  = $urandom_range(400, 100);
            end else begin
                i_out_ready <= 1'b1;
                ready_left  = $urandom_range(30, 1);
            end
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_lookup want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (lookup_results_due.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = lookup_results_due.pop_front();
                checked_cnt++;
                check_field("hit", 32'(o_hit), 32'(want.hit));
                check_field("way", 32'(o_way), 32'(want.way));
                check_field("evicted", 32'(o_evicted), 32'(want.evicted));
                check_field("evicted_block", 32'(o_evicted_block), 32'(want.evicted_block));
                check_field("block_number", 32'(o_block_number), 32'(want.block_number));
                check_field("offset_in_block", 32'(o_offset_in_block),
                            32'(want.offset_in_block));
                check_field("invalidated_mask", 32'(o_invalidated_mask),
                            32'(want.invalidated_mask));
            end
        end
    end

    // Main sequence
    initial begin
        logic [DATA_W-1:0] settings [10];
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            tag_valid[i] = 1'b0;
            tag_block[i] = '0;
            tag_stamp[i] = '0;
        end
        use_count = STAMP_W'(1);
        settings = '{32'd1, 32'd65536, 32'd0, 32'h0001_FFFF, 32'hFFFE_0003,
                     32'd7, 32'd65535, 32'd65537, 32'(int'($urandom_range(65536, 1))),
                     $urandom};

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: fill, hit, refresh, LRU eviction, invalidate and extremes
        push_request(REQ_PROBE, 31'd0);
        push_request(REQ_ACCESS, 31'd0);
        push_request(REQ_PROBE, 31'd1023);
        push_request(REQ_PROBE, 31'd1024);
        push_request(REQ_ACCESS, 31'd1029);
        for (int k = 2; k < 7; k++) begin
            push_request(REQ_ACCESS, BLK_W'(k * 1024 + k));
        end
        push_request(REQ_ACCESS, INDEX_MAX);
        push_request(REQ_ACCESS, 31'd17);
        push_request(REQ_PROBE, 31'd1924);
        push_request(REQ_ACCESS, 31'd8192, 1'b1);
        push_request(REQ_UNUSED, 31'h2AAA_AAAA);
        push_request(REQ_INVAL, 31'd6120);
        push_request(REQ_ACCESS, 31'd9216);
        push_request(REQ_INVAL, 31'd0);
        push_request(REQ_ACCESS, INDEX_MAX);
        push_request(REQ_PROBE, INDEX_MAX - 31'd1023);
        push_request(REQ_INVAL, INDEX_MAX);
        push_request(REQ_PROBE, 31'd3072);

        // Random phases, one per block size setting
        queue_random_phase(112);
        foreach (settings[s]) begin
            write_block_size(settings[s]);
            queue_random_phase(112);
        end

        wait_idle();
        if (lookup_results_due.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", lookup_results_due.size()));
        end

        $display("Checked %0d results over %0d block size settings", checked_cnt, setting_cnt);
        $display("Predicted %0d hits, %0d evictions, %0d entries dropped by invalidate",
                 hit_cnt, evict_cnt, drop_cnt);
        if (mismatch_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
design/lbtc_pkg.sv
design/lbtc_div.sv
design/lbtc_store.sv
design/lru_block_tag_cache.sv
test/tb_top.sv
